// ===== src/rcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared constants, types and command/status bundles of the RMS current meter.
// ----------------------------------------------------------------------------
package rcm_pkg;

  localparam int unsigned AdcBitsDef     = 10;
  localparam int unsigned MidFracBitsDef = 20;
  localparam int unsigned MaxWindowDef   = 4096;

  localparam int unsigned WinW   = 13;
  localparam int unsigned WarmW  = 16;
  localparam int unsigned OfsW   = 17;
  localparam int unsigned ScaleW = 32;
  localparam int unsigned CurW   = 24;
  localparam int unsigned ScaleHalfW = ScaleW / 2;

  localparam logic [WinW-1:0]   WindowRst = 13'd1024;
  localparam logic [WarmW-1:0]  WarmupRst = 16'd1000;
  localparam logic [OfsW-1:0]   OffsetRst = 17'd0;
  localparam logic [ScaleW-1:0] ScaleRst  = 32'd65536;

  typedef enum logic [1:0] {
    REG_WINDOW = 2'd0,
    REG_WARMUP = 2'd1,
    REG_OFFSET = 2'd2,
    REG_SCALE  = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ACC, S_DIV, S_SQL, S_SQRT, S_OFS, S_MUL0, S_MUL1, S_FIN
  } state_e;

  typedef struct packed {
    logic accept;
    logic square;
    logic accum;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic offset;
    logic mul_lo;
    logic mul_hi;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic warm_only;
    logic win_end;
    logic last_step;
    logic out_free;
  } status_t;

endpackage

// ===== src/rms_current_meter_top.sv =====
// A sample passes through accept, square and accumulate; a warmup sample is only accepted.
// The window's last sample then runs the bit-serial divider and the two-bits-per-cycle
// square root, then offset removal, the split multiply and the result hand-off.
// One result is delivered per window; sampling resumes once it is in the output register.
// Reset (rst_ni low, asynchronous) restores register defaults, midpoint 512.0 and warmup.
// ----------------------------------------------------------------------------
// rms_current_meter_top
// RMS current meter with DC midpoint tracking, one result per sample window.
// ----------------------------------------------------------------------------
module rms_current_meter_top #(
  parameter int unsigned ADC_BITS      = rcm_pkg::AdcBitsDef,
  parameter int unsigned MID_FRAC_BITS = rcm_pkg::MidFracBitsDef,
  parameter int unsigned MAX_WINDOW    = rcm_pkg::MaxWindowDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((ADC_BITS+7)/8)*8-1:0]     s_axis_tdata,   // sample
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rcm_pkg::CurW-1:0]          m_axis_tdata,   // current_scaled
  output logic [1:0]                        m_axis_tuser,   // below_offset, saturated
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [1:0]                        cfg_addr_i,
  input  logic [rcm_pkg::ScaleW-1:0]        cfg_data_i
);

  rcm_pkg::cmd_t    cmd;
  rcm_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  rcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rcm_datapath #(
    .ADC_BITS      (ADC_BITS),
    .MID_FRAC_BITS (MID_FRAC_BITS),
    .MAX_WINDOW    (MAX_WINDOW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i),
    .cfg_idx_i        (rcm_pkg::reg_idx_e'(cfg_addr_i)),
    .cfg_data_i       (cfg_data_i),
    .sample_i         (s_axis_tdata[ADC_BITS-1:0]),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .current_scaled_o (m_axis_tdata),
    .below_offset_o   (m_axis_tuser[0]),
    .saturated_o      (m_axis_tuser[1])
  );

endmodule

// ===== src/rcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcm_ctrl
// Sequencer: sample intake, accumulation and the window-end arithmetic steps.
// ----------------------------------------------------------------------------
module rcm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rcm_pkg::status_t status_i,
  output rcm_pkg::cmd_t    cmd_o
);

  rcm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rcm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!status_i.warm_only) state_d = rcm_pkg::S_SQ;
        end
      end
      rcm_pkg::S_SQ: begin
        cmd_o.square = 1'b1;
        state_d = rcm_pkg::S_ACC;
      end
      rcm_pkg::S_ACC: begin
        cmd_o.accum = 1'b1;
        state_d = status_i.win_end ? rcm_pkg::S_DIV : rcm_pkg::S_IDLE;
      end
      rcm_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.last_step) state_d = rcm_pkg::S_SQL;
      end
      rcm_pkg::S_SQL: begin
        cmd_o.sqrt_load = 1'b1;
        state_d = rcm_pkg::S_SQRT;
      end
      rcm_pkg::S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.last_step) state_d = rcm_pkg::S_OFS;
      end
      rcm_pkg::S_OFS: begin
        cmd_o.offset = 1'b1;
        state_d = rcm_pkg::S_MUL0;
      end
      rcm_pkg::S_MUL0: begin
        cmd_o.mul_lo = 1'b1;
        state_d = rcm_pkg::S_MUL1;
      end
      rcm_pkg::S_MUL1: begin
        cmd_o.mul_hi = 1'b1;
        state_d = rcm_pkg::S_FIN;
      end
      rcm_pkg::S_FIN: begin
        // Hold the finished result until the output register is free.
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = rcm_pkg::S_IDLE;
        end
      end
      default: state_d = rcm_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== src/rcm_datapath.sv =====
// ----------------------------------------------------------------------------
// rcm_datapath
// Registers, midpoint filter, square accumulator, divider, root and scaling.
// ----------------------------------------------------------------------------
module rcm_datapath #(
  parameter int unsigned ADC_BITS      = rcm_pkg::AdcBitsDef,
  parameter int unsigned MID_FRAC_BITS = rcm_pkg::MidFracBitsDef,
  parameter int unsigned MAX_WINDOW    = rcm_pkg::MaxWindowDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  rcm_pkg::reg_idx_e           cfg_idx_i,
  input  logic [rcm_pkg::ScaleW-1:0]  cfg_data_i,
  input  logic [ADC_BITS-1:0]         sample_i,
  input  rcm_pkg::cmd_t               cmd_i,
  output rcm_pkg::status_t            status_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [rcm_pkg::CurW-1:0]    current_scaled_o,
  output logic                        below_offset_o,
  output logic                        saturated_o
);

  localparam int unsigned MidW   = ADC_BITS + MID_FRAC_BITS;
  localparam int unsigned MagW   = ADC_BITS + 8;
  localparam int unsigned SqW    = 2 * MagW;
  localparam int unsigned CntW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SumW   = SqW + CntW;
  localparam int unsigned RootW  = (SumW + 1) / 2;
  localparam int unsigned SremW  = RootW + 1;
  localparam int unsigned RadW   = 2 * RootW;
  localparam int unsigned StepW  = $clog2(SumW + 1);
  localparam int unsigned HalfW  = rcm_pkg::ScaleHalfW;
  localparam int unsigned PartW  = RootW + HalfW;
  localparam int unsigned ProdW  = RootW + rcm_pkg::ScaleW + 1;
  localparam int unsigned FiltSh = MID_FRAC_BITS - 8;

  // Configuration registers.
  logic [rcm_pkg::WinW-1:0]   window_q;
  logic [rcm_pkg::WarmW-1:0]  warmup_q;
  logic [rcm_pkg::OfsW-1:0]   offset_q;
  logic [rcm_pkg::ScaleW-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= rcm_pkg::WindowRst;
      warmup_q <= rcm_pkg::WarmupRst;
      offset_q <= rcm_pkg::OffsetRst;
      scale_q  <= rcm_pkg::ScaleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcm_pkg::REG_WINDOW: window_q <= cfg_data_i[rcm_pkg::WinW-1:0];
        rcm_pkg::REG_WARMUP: warmup_q <= cfg_data_i[rcm_pkg::WarmW-1:0];
        rcm_pkg::REG_OFFSET: offset_q <= cfg_data_i[rcm_pkg::OfsW-1:0];
        rcm_pkg::REG_SCALE:  scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Midpoint filter and offset-removed sample.
  logic [MidW-1:0]         mid_q, mid_new;
  logic [MidW-1:0]         target;
  logic signed [MidW:0]    diff, resid, filt_full;
  logic signed [MagW:0]    filt_q;
  logic [rcm_pkg::WarmW-1:0] warm_cnt_q;
  logic                    warming_q;
  logic                    warm_only;

  assign target    = {sample_i, {MID_FRAC_BITS{1'b0}}};
  assign diff      = $signed({1'b0, target}) - $signed({1'b0, mid_q});
  assign mid_new   = mid_q + MidW'(diff >>> ADC_BITS);
  assign resid     = $signed({1'b0, target}) - $signed({1'b0, mid_new});
  assign filt_full = resid >>> FiltSh;
  assign warm_only = warming_q && (warm_cnt_q < warmup_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q      <= MidW'(1) << (MidW - 1);
      warm_cnt_q <= '0;
      warming_q  <= 1'b1;
    end else if (cmd_i.accept) begin
      mid_q <= mid_new;
      if (warm_only) begin
        warm_cnt_q <= warm_cnt_q + 1'b1;
        if ((warm_cnt_q + 1'b1) >= warmup_q) warming_q <= 1'b0;
      end else begin
        warming_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) filt_q <= filt_full[MagW:0];
  end

  // Square and accumulate.
  logic [MagW-1:0] mag;
  logic [SqW-1:0]  sq_q;
  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] cnt_q, cnt_inc, win_eff;

  assign mag = filt_q[MagW] ? MagW'(-filt_q) : filt_q[MagW-1:0];

  always_comb begin
    if (window_q == '0) begin
      win_eff = CntW'(1);
    end else if (32'(window_q) > 32'(MAX_WINDOW)) begin
      win_eff = CntW'(MAX_WINDOW);
    end else begin
      win_eff = CntW'(window_q);
    end
  end

  assign cnt_inc = cnt_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) sq_q <= mag * mag;
  end

  // Divider state (quotient shifted in over the dividend) and root state.
  logic [SumW-1:0]  dq_q;
  logic [CntW-1:0]  den_q, rem_q;
  logic [CntW:0]    rem_sh;
  logic             rem_ge;
  logic [StepW-1:0] step_q;
  logic [RadW-1:0]  rad_q;
  logic [RootW-1:0] root_q;
  logic [RootW:0]   srem_q;
  logic [RootW+2:0] rt, trial;
  logic             rt_ge;
  logic             end_win;

  assign end_win = cnt_inc >= win_eff;
  assign rem_sh  = {rem_q, dq_q[SumW-1]};
  assign rem_ge  = rem_sh >= {1'b0, den_q};
  assign rt      = {srem_q, rad_q[RadW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign rt_ge   = rt >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.accum) begin
      if (end_win) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_q + SumW'(sq_q);
        cnt_q <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accum) begin
      dq_q   <= sum_q + SumW'(sq_q);
      den_q  <= cnt_inc;
      rem_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? CntW'(rem_sh - {1'b0, den_q}) : rem_sh[CntW-1:0];
      dq_q   <= {dq_q[SumW-2:0], rem_ge};
      step_q <= step_q + 1'b1;
    end else if (cmd_i.sqrt_load) begin
      rad_q  <= RadW'(dq_q);
      root_q <= '0;
      srem_q <= '0;
      step_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      srem_q <= rt_ge ? SremW'(rt - trial) : rt[RootW:0];
      root_q <= {root_q[RootW-2:0], rt_ge};
      step_q <= step_q + 1'b1;
    end
  end

  // Offset removal, split multiply and rounding.
  logic [RootW-1:0] val_q;
  logic             below_q;
  logic [PartW-1:0] plo_q, phi_q;
  logic [ProdW-1:0] prod;
  logic             sat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.offset) begin
      below_q <= root_q < RootW'(offset_q);
      val_q   <= (root_q < RootW'(offset_q)) ? '0 : root_q - RootW'(offset_q);
    end
    if (cmd_i.mul_lo) plo_q <= val_q * scale_q[HalfW-1:0];
    if (cmd_i.mul_hi) phi_q <= val_q * scale_q[rcm_pkg::ScaleW-1:HalfW];
  end

  assign prod = (ProdW'(phi_q) << HalfW) + ProdW'(plo_q) + (ProdW'(1) << 23);
  assign sat  = |prod[ProdW-1:24+rcm_pkg::CurW];

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      current_scaled_o <= sat ? {rcm_pkg::CurW{1'b1}} : prod[24 +: rcm_pkg::CurW];
      below_offset_o   <= below_q;
      saturated_o      <= sat;
    end
  end

  always_comb begin
    status_o.warm_only = warm_only;
    status_o.win_end   = end_win;
    status_o.last_step = cmd_i.div_step ? (step_q == StepW'(SumW - 1))
                                        : (step_q == StepW'(RootW - 1));
    status_o.out_free  = !out_valid_o || out_ready_i;
  end

endmodule

// ===== src/rcm_checker.sv =====
// ----------------------------------------------------------------------------
// rcm_checker
// Port-level checks of the RMS current meter, bound to the top level.
// ----------------------------------------------------------------------------
module rcm_checker #(
  parameter int unsigned ADC_BITS      = rcm_pkg::AdcBitsDef,
  parameter int unsigned MID_FRAC_BITS = rcm_pkg::MidFracBitsDef,
  parameter int unsigned MAX_WINDOW    = rcm_pkg::MaxWindowDef
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [((ADC_BITS+7)/8)*8-1:0] s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rcm_pkg::CurW-1:0]      m_axis_tdata,
  input logic [1:0]                    m_axis_tuser,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [1:0]                    cfg_addr_i,
  input logic [rcm_pkg::ScaleW-1:0]    cfg_data_i
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // A clamped result is zero and never flagged as saturated.
  a_below_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("below-offset result is not zero");

  // A saturated result carries the full-scale value.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> &m_axis_tdata)
    else $error("saturated result is not full scale");

  // A new result only appears at the end of window arithmetic, never straight after intake.
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while the input side was open");

endmodule

bind rms_current_meter_top rcm_checker #(
  .ADC_BITS      (ADC_BITS),
  .MID_FRAC_BITS (MID_FRAC_BITS),
  .MAX_WINDOW    (MAX_WINDOW)
) u_rcm_checker (.*);
